/* design/pol_pkg.sv */
// shared constants, codes and types of the positional ordered list
`default_nettype none
package pol_pkg;

  // storage geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // fixed field widths of the channels
  localparam int OP_W   = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 5;
  localparam int ST_W   = 2;
  localparam int ECNT_W = 5;

  // common width for comparing a position against the count
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_POS   = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_END   = 3'd2;
  localparam logic [OP_W-1:0] OP_RM_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_RM_POS    = 3'd4;
  localparam logic [OP_W-1:0] OP_RM_END    = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  // shift command broadcast along the cell row
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] idx;
  } shift_ctrl_t;

  // decoded operation
  typedef struct packed {
    shift_ctrl_t      shift;
    logic             rd_err;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] cnt_nxt;
  } dec_t;

endpackage
`default_nettype wire

/* design/pol_in_if.sv */
// request channel: opcode, value and position
`default_nettype none
interface pol_in_if
  import pol_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface
`default_nettype wire

/* design/pol_out_if.sv */
// result channel: removed value, status and element count
`default_nettype none
interface pol_out_if
  import pol_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] removed_value;
  logic [ST_W-1:0]         status;
  logic [ECNT_W-1:0]       element_count;

  modport source (output valid, output removed_value, output status, output element_count,
                  input ready);
  modport sink   (input valid, input removed_value, input status, input element_count,
                  output ready);
endinterface
`default_nettype wire

/* design/pol_cell.sv */
// one list slot: holds, shifts toward the back, shifts toward the front or loads
`default_nettype none
module pol_cell
  import pol_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [IDX_W-1:0]      slot_idx,
  input  wire shift_ctrl_t           ctrl,
  input  wire logic [DATA_WIDTH-1:0] ins_value,
  input  wire logic [DATA_WIDTH-1:0] left_data,
  input  wire logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0]      data_o
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  // pick the new content from the shift command
  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins) begin
      if (slot_idx > ctrl.idx) begin
        data_nxt = left_data;
      end else if (slot_idx == ctrl.idx) begin
        data_nxt = ins_value;
      end
    end else if (ctrl.rem) begin
      if (slot_idx >= ctrl.idx) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule
`default_nettype wire

/* design/pol_decode.sv */
// turns opcode, position and count into a shift command, status and next count
`default_nettype none
module pol_decode
  import pol_pkg::*;
(
  input  wire logic [OP_W-1:0]  opcode,
  input  wire logic [POS_W-1:0] position,
  input  wire logic [CNT_W-1:0] cnt,
  output dec_t                  dec
);

  logic             full;
  logic             empty;
  logic             pos_gt;
  logic             pos_eq;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] end_idx;

  assign full     = (cnt >= CNT_W'(DEPTH));
  assign empty    = (cnt == '0);
  assign pos_gt   = (CMP_W'(position) > CMP_W'(cnt));
  assign pos_eq   = (CMP_W'(position) == CMP_W'(cnt));
  assign last_idx = IDX_W'(cnt - CNT_W'(1));
  assign pos_idx  = IDX_W'(position);
  assign end_idx  = IDX_W'(cnt);

  // operation decode
  always_comb begin
    dec.shift  = '0;
    dec.rd_err = 1'b0;
    dec.status = ST_DONE;
    unique case (opcode)
      OP_INS_FRONT: begin
        if (full) begin
          dec.status = ST_FULL;
        end else begin
          dec.shift.ins = 1'b1;
        end
      end
      OP_INS_POS: begin
        if (empty) begin
          dec.shift.ins = 1'b1;
        end else if (pos_gt) begin
          dec.status = ST_RANGE;
        end else if (full) begin
          dec.status = ST_FULL;
        end else begin
          dec.shift.ins = 1'b1;
          dec.shift.idx = pos_idx;
        end
      end
      OP_INS_END: begin
        if (full) begin
          dec.status = ST_FULL;
        end else begin
          dec.shift.ins = 1'b1;
          dec.shift.idx = end_idx;
        end
      end
      OP_RM_FRONT: begin
        if (empty) begin
          dec.rd_err = 1'b1;
          dec.status = ST_EMPTY;
        end else begin
          dec.shift.rem = 1'b1;
        end
      end
      OP_RM_POS: begin
        if (empty) begin
          dec.rd_err = 1'b1;
          dec.status = ST_EMPTY;
        end else if (pos_gt) begin
          dec.rd_err = 1'b1;
          dec.status = ST_RANGE;
        end else begin
          dec.shift.rem = 1'b1;
          dec.shift.idx = pos_eq ? last_idx : pos_idx;
        end
      end
      OP_RM_END: begin
        if (empty) begin
          dec.rd_err = 1'b1;
          dec.status = ST_EMPTY;
        end else begin
          dec.shift.rem = 1'b1;
          dec.shift.idx = last_idx;
        end
      end
      default: begin
        dec.shift = '0;
      end
    endcase
    // count after the operation
    dec.cnt_nxt = cnt + CNT_W'(dec.shift.ins) - CNT_W'(dec.shift.rem);
  end

endmodule
`default_nettype wire

/* design/positional_ordered_list.sv */
// positional ordered list: decoder, row of shifting cells and result register
// an accepted item's result appears in the output register in the next cycle
// throughput: one item per cycle while ready is high; every cell shifts in parallel in the accept cycle
// ready stays high while the output register is empty or being drained
// reset clears the element count and the output valid; slot contents are not cleared
`default_nettype none
module positional_ordered_list
  import pol_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  pol_in_if.sink     in_ch,
  pol_out_if.source  out_ch
);

  logic                  accept;
  dec_t                  dec;
  shift_ctrl_t           shift_go;
  logic [CNT_W-1:0]      cnt_r;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] ins_word;
  logic [DATA_WIDTH-1:0] rm_word;

  logic                  out_valid_r;
  logic [VAL_W-1:0]      out_value_r;
  logic [ST_W-1:0]       out_status_r;
  logic [ECNT_W-1:0]     out_count_r;

  // handshake
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  pol_decode u_decode (
    .opcode   (in_ch.opcode),
    .position (in_ch.position),
    .cnt      (cnt_r),
    .dec      (dec)
  );

  // shift only on an accepted item
  always_comb begin
    shift_go     = dec.shift;
    shift_go.ins = dec.shift.ins && accept;
    shift_go.rem = dec.shift.rem && accept;
  end

  assign ins_word = DATA_WIDTH'(in_ch.value);

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    pol_cell u_cell (
      .clk        (clk),
      .slot_idx   (IDX_W'(i)),
      .ctrl       (shift_go),
      .ins_value  (ins_word),
      .left_data  (left_d),
      .right_data (right_d),
      .data_o     (cell_data[i])
    );
  end

  // removed element or error marker
  always_comb begin
    if (dec.shift.rem) begin
      rm_word = cell_data[dec.shift.idx];
    end else if (dec.rd_err) begin
      rm_word = '1;
    end else begin
      rm_word = '0;
    end
  end

  // element count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= dec.cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r  <= VAL_W'(rm_word);
      out_status_r <= dec.status;
      out_count_r  <= ECNT_W'(dec.cnt_nxt);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.removed_value = out_value_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.element_count = out_count_r;

  // count stays within the row
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("element count above depth");

  // an accepted insert grows the list by one
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    accept && dec.shift.ins |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("insert did not grow the count");

  // empty status only on an empty list
  a_empty_st: assert property (@(posedge clk) disable iff (!rst_n)
    accept && dec.status == ST_EMPTY |-> cnt_r == '0)
    else $error("empty status with elements held");

  // every accepted item leaves a result
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item produced no result");

endmodule
`default_nettype wire
